>>> rtl/assert_macros.svh
// Assertion macros included by the top-level core RTL file.
// ASSERT_HOLDS checks a property on every rising clock edge outside reset.
// ASSERT_NEVER checks that a condition is never true outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");
`else
`define ASSERT_HOLDS(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

>>> rtl/ledfs_pkg.sv
package ledfs_pkg;

   // Opcodes of a request word
   localparam logic [2:0] OP_SET_PIXEL = 3'd0;
   localparam logic [2:0] OP_SET_FIRST = 3'd1;
   localparam logic [2:0] OP_FILL      = 3'd2;
   localparam logic [2:0] OP_REFRESH   = 3'd3;
   localparam logic [2:0] OP_TICK      = 3'd4;

   // Line timing in 250 ns slots
   localparam logic [2:0]  SLOT_LAST      = 3'd4;
   localparam logic [2:0]  HIGH_SLOTS_ONE = 3'd4;
   localparam logic [2:0]  HIGH_SLOTS_ZERO = 3'd1;
   localparam logic [4:0]  BIT_LAST       = 5'd23;
   localparam logic [15:0] RESET_SLOTS_DEFAULT = 16'd1200;

   typedef struct packed {
      logic [2:0] opcode;
      logic [6:0] pixel_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] fill_value;
   } req_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic rejected;
   } rsp_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic wr_pixel;
      logic sweep_start;
      logic sweep_step;
      logic fill;
      logic refresh_start;
      logic load_word;
      logic tick_data;
      logic gap_start;
      logic gap_step;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic idx_ok;
      logic cnt_zero;
      logic sweep_last;
      logic frame_done;
      logic slot_last;
      logic bit_last;
      logic gap_last;
      logic gap_zero;
      logic level;
   } sts_type;

endpackage

>>> rtl/serial_rgb_led_frame_sender_core.sv
// Serial RGB LED frame sender: keeps green, red and blue bytes per pixel
// and drives a one-wire LED chain, one 250 ns slot per tick word.
// Request channel: start with req_data, taken when start is high and busy
// is low. Opcodes set one pixel, set the first n pixels, fill the store,
// start a refresh, or tick one slot of the data line.
// Result channel: one word per request on rsp_data, in the cycle after the
// request is taken, marked by rsp_valid for a single cycle. The receiver
// cannot stall; results are never held.
// Config: csr_we writes csr_wdata into the reset-gap length (slots).
// Throughput: one word per cycle for ticks, single set, fill and all
// rejected words. Set-first-n holds busy for n cycles after it is taken,
// one store row written per cycle. A non-empty refresh holds busy while
// the first pixel is read from the store; ticks then run one per cycle,
// with each next pixel prefetched through the registered store read port.
// Reset: the store reads as all zeros, the line is idle, the gap length is
// 1200 slots; no clearing pass is needed, row valid bits clear at once.
module serial_rgb_led_frame_sender_core #(
   parameter int unsigned PIXELS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  ledfs_pkg::req_type req_data,
   output logic               rsp_valid,
   output ledfs_pkg::rsp_type rsp_data,
   input  logic               csr_we,
   input  logic [15:0]        csr_wdata
);

   ledfs_pkg::cmd_type cmd;
   ledfs_pkg::sts_type sts;

   ledfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req_data),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   ledfs_dp #(
      .PIXELS (PIXELS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req_data),
      .cmd       (cmd),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .sts       (sts)
   );

`include "assert_macros.svh"

   // Every taken word yields exactly one result in the next cycle
   `ASSERT_HOLDS(a_rsp_follows_req, clock, reset, (start && !busy) |=> rsp_valid)
   `ASSERT_HOLDS(a_rsp_only_after_req, clock, reset, rsp_valid |-> $past(start && !busy))
   // A high line level comes only from a tick word
   `ASSERT_HOLDS(a_level_from_tick, clock, reset,
      (rsp_valid && rsp_data.line_level) |-> $past(req_data.opcode == ledfs_pkg::OP_TICK))
   // Ticks are never rejected
   `ASSERT_HOLDS(a_tick_not_rejected, clock, reset,
      (start && !busy && req_data.opcode == ledfs_pkg::OP_TICK) |=> !rsp_data.rejected)
   // No store write while the frame is being sent
   `ASSERT_NEVER(a_no_write_in_frame, clock, reset,
      (cmd.wr_pixel || cmd.sweep_step) && (cmd.tick_data || cmd.load_word))

endmodule

>>> rtl/ledfs_dp.sv
module ledfs_dp #(
   parameter int unsigned PIXELS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  ledfs_pkg::req_type  req,
   input  ledfs_pkg::cmd_type  cmd,
   input  logic                csr_we,
   input  logic [15:0]         csr_wdata,
   output ledfs_pkg::sts_type  sts
);

   localparam int unsigned AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam int unsigned CW = $clog2(PIXELS + 1);

   // Pixel store: one row of green, red, blue per pixel
   logic [23:0]       mem [PIXELS];
   logic [23:0]       rd_data_ff;
   logic              rd_vld_ff;
   logic [PIXELS-1:0] vld_ff, vld_in;
   logic [7:0]        fill_ff, fill_in;

   logic [15:0]   reset_slots_ff, reset_slots_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [23:0]   pix_ff, pix_in;
   logic [23:0]   cur_ff, cur_in;
   logic [2:0]    slot_ff, slot_in;
   logic [4:0]    bit_ff, bit_in;
   logic [15:0]   gap_ff, gap_in;

   logic [7:0]    idx8;
   logic [7:0]    clamp8;
   logic [CW-1:0] n_clamp;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [23:0]   wr_data;
   logic          rd_en;
   logic [23:0]   word;

   // Clamp the pixel count to the store size
   assign idx8    = {1'b0, req.pixel_index};
   assign clamp8  = (idx8 > 8'(PIXELS)) ? 8'(PIXELS) : idx8;
   assign n_clamp = CW'(clamp8);

   // Write port: single pixel set or sweep over the first n pixels
   assign wr_en   = cmd.wr_pixel | cmd.sweep_step;
   assign wr_addr = cmd.wr_pixel ? AW'(req.pixel_index - 7'd1) : ptr_ff[AW-1:0];
   assign wr_data = cmd.wr_pixel ? {req.green, req.red, req.blue} : pix_ff;

   // Read port follows the pointer to the next pixel
   assign rd_en = (ptr_ff < CW'(PIXELS));
   assign word  = rd_vld_ff ? rd_data_ff : {fill_ff, fill_ff, fill_ff};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[ptr_ff[AW-1:0]];
         rd_vld_ff  <= vld_ff[ptr_ff[AW-1:0]];
      end
   end

   // Next-state logic for counters and shift register
   always_comb begin
      reset_slots_in = reset_slots_ff;
      vld_in         = vld_ff;
      fill_in        = fill_ff;
      ptr_in         = ptr_ff;
      count_in       = count_ff;
      pix_in         = pix_ff;
      cur_in         = cur_ff;
      slot_in        = slot_ff;
      bit_in         = bit_ff;
      gap_in         = gap_ff;

      if (csr_we) begin
         reset_slots_in = csr_wdata;
      end
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
      if (cmd.fill) begin
         vld_in  = '0;
         fill_in = req.fill_value;
      end
      if (cmd.sweep_start) begin
         ptr_in   = '0;
         count_in = n_clamp;
         pix_in   = {req.green, req.red, req.blue};
      end
      if (cmd.sweep_step) begin
         ptr_in = ptr_ff + 1'b1;
      end
      if (cmd.refresh_start) begin
         ptr_in   = '0;
         count_in = n_clamp;
      end
      // Load next pixel, or advance one slot of the current bit
      if (cmd.load_word) begin
         cur_in  = word;
         ptr_in  = ptr_ff + 1'b1;
         slot_in = '0;
         bit_in  = '0;
      end else if (cmd.tick_data) begin
         if (slot_ff == ledfs_pkg::SLOT_LAST) begin
            slot_in = '0;
            cur_in  = {cur_ff[22:0], 1'b0};
            bit_in  = bit_ff + 1'b1;
         end else begin
            slot_in = slot_ff + 1'b1;
         end
      end
      if (cmd.gap_start) begin
         gap_in = reset_slots_ff;
      end else if (cmd.gap_step) begin
         gap_in = gap_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_slots_ff <= ledfs_pkg::RESET_SLOTS_DEFAULT;
         vld_ff         <= '0;
         fill_ff        <= '0;
         ptr_ff         <= '0;
         count_ff       <= '0;
         slot_ff        <= '0;
         bit_ff         <= '0;
         gap_ff         <= '0;
      end else begin
         reset_slots_ff <= reset_slots_in;
         vld_ff         <= vld_in;
         fill_ff        <= fill_in;
         ptr_ff         <= ptr_in;
         count_ff       <= count_in;
         slot_ff        <= slot_in;
         bit_ff         <= bit_in;
         gap_ff         <= gap_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
      cur_ff <= cur_in;
   end

   // Status toward the controller
   always_comb begin
      sts.idx_ok     = (req.pixel_index != 7'd0) && (idx8 <= 8'(PIXELS));
      sts.cnt_zero   = (n_clamp == '0);
      sts.sweep_last = (CW'(ptr_ff + 1'b1) == count_ff);
      sts.frame_done = (ptr_ff >= count_ff);
      sts.slot_last  = (slot_ff == ledfs_pkg::SLOT_LAST);
      sts.bit_last   = (bit_ff == ledfs_pkg::BIT_LAST);
      sts.gap_last   = (gap_ff == 16'd1);
      sts.gap_zero   = (reset_slots_ff == 16'd0);
      sts.level      = (slot_ff < (cur_ff[23] ? ledfs_pkg::HIGH_SLOTS_ONE
                                              : ledfs_pkg::HIGH_SLOTS_ZERO));
   end

endmodule

>>> rtl/ledfs_ctrl.sv
module ledfs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  ledfs_pkg::req_type req,
   input  ledfs_pkg::sts_type sts,
   output ledfs_pkg::cmd_type cmd,
   output logic               busy,
   output logic               rsp_valid,
   output ledfs_pkg::rsp_type rsp_data
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SWEEP = 6'b000010,
      ST_FETCH = 6'b000100,
      ST_LOAD  = 6'b001000,
      ST_DATA  = 6'b010000,
      ST_GAP   = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic               rsp_valid_ff;
   ledfs_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic accept;
   logic is_tick;
   logic lvl;
   logic rej;
   logic busy_res;

   assign busy    = (state_ff == ST_SWEEP) || (state_ff == ST_FETCH) || (state_ff == ST_LOAD);
   assign accept  = start && !busy;
   assign is_tick = (req.opcode == ledfs_pkg::OP_TICK);

   // Decode words and sequence the frame
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      lvl      = 1'b0;
      rej      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req.opcode)
                  ledfs_pkg::OP_TICK: begin
                  end
                  ledfs_pkg::OP_SET_PIXEL: begin
                     if (sts.idx_ok) begin
                        cmd.wr_pixel = 1'b1;
                     end else begin
                        rej = 1'b1;
                     end
                  end
                  ledfs_pkg::OP_SET_FIRST: begin
                     if (!sts.cnt_zero) begin
                        cmd.sweep_start = 1'b1;
                        state_in        = ST_SWEEP;
                     end
                  end
                  ledfs_pkg::OP_FILL: begin
                     cmd.fill = 1'b1;
                  end
                  ledfs_pkg::OP_REFRESH: begin
                     cmd.refresh_start = 1'b1;
                     if (!sts.cnt_zero) begin
                        state_in = ST_FETCH;
                     end else if (!sts.gap_zero) begin
                        cmd.gap_start = 1'b1;
                        state_in      = ST_GAP;
                     end
                  end
                  default: begin
                     rej = 1'b1;
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (sts.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_FETCH: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load_word = 1'b1;
            state_in      = ST_DATA;
         end
         ST_DATA: begin
            if (accept) begin
               if (is_tick) begin
                  cmd.tick_data = 1'b1;
                  lvl           = sts.level;
                  if (sts.slot_last && sts.bit_last) begin
                     if (!sts.frame_done) begin
                        cmd.load_word = 1'b1;
                     end else if (sts.gap_zero) begin
                        state_in = ST_IDLE;
                     end else begin
                        cmd.gap_start = 1'b1;
                        state_in      = ST_GAP;
                     end
                  end
               end else begin
                  rej = 1'b1;
               end
            end
         end
         ST_GAP: begin
            if (accept) begin
               if (is_tick) begin
                  cmd.gap_step = 1'b1;
                  if (sts.gap_last) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  rej = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A tick reports the phase it ran in, other words the phase after them
      if (is_tick) begin
         busy_res = (state_ff == ST_DATA) || (state_ff == ST_GAP);
      end else begin
         busy_res = (state_in == ST_FETCH) || (state_in == ST_LOAD) ||
                    (state_in == ST_DATA) || (state_in == ST_GAP);
      end
      rsp_data_in = '{line_level: lvl, busy_res: busy_res, rejected: rej};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= accept;
      end
   end

   // Hold the result word for its one strobe cycle
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> verif/serial_rgb_led_frame_sender_core_tb.sv
`timescale 1ns / 100ps

module serial_rgb_led_frame_sender_core_tb;

   localparam int unsigned PIXELS      = 64;
   localparam int unsigned STORE_BYTES = PIXELS * 3;
   localparam int unsigned ITEM_TARGET = 1150;
   localparam int unsigned RANDOM_STOP = ITEM_TARGET - 120;
   localparam int unsigned CYCLE_LIMIT = 400_000;
   localparam int unsigned TAIL_CYCLES = 16;
   localparam int unsigned MAX_SHOWN   = 30;

   typedef enum logic [2:0] {
      SEND_IDLE = 3'b001,
      SEND_DATA = 3'b010,
      SEND_GAP  = 3'b100
   } send_state_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   ledfs_pkg::req_type req_data = '0;
   logic               rsp_valid;
   ledfs_pkg::rsp_type rsp_data;
   logic               csr_we = 1'b0;
   logic [15:0]        csr_wdata = '0;

   // Line predictor state
   logic [7:0]     store_mem [0:STORE_BYTES-1];
   send_state_type snd_state;
   int unsigned    byte_ptr;
   logic [2:0]     bit_ptr;
   int unsigned    slot_cnt;
   logic [15:0]    gap_left;
   int unsigned    frame_len;
   logic [15:0]    gap_len;

   // Words waiting to be sent and line results still due
   ledfs_pkg::req_type word_q [$];
   ledfs_pkg::rsp_type slot_rsp_q [$];

   logic        idle_en = 1'b0;
   int unsigned idle_left;
   int unsigned cycle_cnt = 0;
   int unsigned err_cnt = 0;
   int unsigned words_queued = 0;
   int unsigned words_taken = 0;
   int unsigned words_refused = 0;
   int unsigned frames_sent = 0;
   int unsigned rsp_checked = 0;

   serial_rgb_led_frame_sender_core #(
      .PIXELS (PIXELS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic int unsigned pixel_count(input logic [6:0] n);
      return (32'(n) > PIXELS) ? PIXELS : 32'(n);
   endfunction

   function automatic void put_pixel(input int unsigned pix, input ledfs_pkg::req_type w);
      store_mem[pix * 3]     = w.green;
      store_mem[pix * 3 + 1] = w.red;
      store_mem[pix * 3 + 2] = w.blue;
   endfunction

   function automatic void open_gap();
      if (gap_len == 16'd0) begin
         snd_state = SEND_IDLE;
      end else begin
         snd_state = SEND_GAP;
         gap_left  = gap_len;
      end
   endfunction

   // Advance the line by one word and return the result it causes
   function automatic ledfs_pkg::rsp_type line_step(input ledfs_pkg::req_type w);
      ledfs_pkg::rsp_type r;
      logic [7:0]         cur_byte;
      int unsigned        n;
      r = '0;
      if (w.opcode == ledfs_pkg::OP_TICK) begin
         if (snd_state == SEND_DATA) begin
            cur_byte = (byte_ptr < STORE_BYTES) ? store_mem[byte_ptr] : 8'h00;
            r.line_level = (slot_cnt < 32'(cur_byte[bit_ptr] ? ledfs_pkg::HIGH_SLOTS_ONE
                                                             : ledfs_pkg::HIGH_SLOTS_ZERO));
            r.busy_res = 1'b1;
            slot_cnt++;
            if (slot_cnt > 32'(ledfs_pkg::SLOT_LAST)) begin
               slot_cnt = 0;
               if (bit_ptr == 3'd0) begin
                  bit_ptr = 3'd7;
                  byte_ptr++;
                  if (byte_ptr >= frame_len)
                     open_gap();
               end else begin
                  bit_ptr--;
               end
            end
         end else if (snd_state == SEND_GAP) begin
            r.busy_res = 1'b1;
            if (gap_left != 16'd0)
               gap_left--;
            if (gap_left == 16'd0)
               snd_state = SEND_IDLE;
         end
      end else if (snd_state != SEND_IDLE || w.opcode > ledfs_pkg::OP_TICK) begin
         r.rejected = 1'b1;
      end else if (w.opcode == ledfs_pkg::OP_SET_PIXEL) begin
         if (w.pixel_index == 7'd0 || w.pixel_index > 7'(PIXELS))
            r.rejected = 1'b1;
         else
            put_pixel(32'(w.pixel_index) - 32'd1, w);
      end else if (w.opcode == ledfs_pkg::OP_SET_FIRST) begin
         n = pixel_count(w.pixel_index);
         for (int unsigned i = 0; i < n; i++)
            put_pixel(i, w);
      end else if (w.opcode == ledfs_pkg::OP_FILL) begin
         foreach (store_mem[i])
            store_mem[i] = w.fill_value;
      end else begin
         frame_len = pixel_count(w.pixel_index) * 3;
         byte_ptr  = 0;
         bit_ptr   = 3'd7;
         slot_cnt  = 0;
         if (frame_len == 0)
            open_gap();
         else
            snd_state = SEND_DATA;
      end
      if (w.opcode != ledfs_pkg::OP_TICK)
         r.busy_res = (snd_state != SEND_IDLE);
      return r;
   endfunction

   // Feed request words from the queue, with random idle bursts
   always @(posedge clock) begin
      if (reset) begin
         start     <= 1'b0;
         idle_left <= 0;
      end else if (!start || !busy) begin
         if (idle_left != 0) begin
            idle_left <= idle_left - 1;
            start     <= 1'b0;
         end else if (word_q.size() != 0) begin
            if (idle_en && $urandom_range(0, 11) == 0) begin
               idle_left <= $urandom_range(0, 18);
               start     <= 1'b0;
            end else begin
               req_data <= word_q.pop_front();
               start    <= 1'b1;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Predict each accepted word and check each result word against the oldest one due
   always @(posedge clock) begin
      ledfs_pkg::rsp_type due;
      if (!reset) begin
         if (csr_we)
            gap_len = csr_wdata;
         if (start && !busy) begin
            if (req_data.opcode == ledfs_pkg::OP_REFRESH && snd_state == SEND_IDLE)
               frames_sent++;
            due = line_step(req_data);
            slot_rsp_q.push_back(due);
            words_taken++;
            if (due.rejected)
               words_refused++;
         end
         if (rsp_valid) begin
            if (slot_rsp_q.size() == 0) begin
               err_cnt++;
               if (err_cnt <= MAX_SHOWN)
                  $display("%0t: result word with none due: expected none got %b",
                           $time, rsp_data);
            end else begin
               due = slot_rsp_q.pop_front();
               rsp_checked++;
               if (rsp_data.line_level !== due.line_level) begin
                  err_cnt++;
                  if (err_cnt <= MAX_SHOWN)
                     $display("%0t: line_level expected %b got %b", $time,
                              due.line_level, rsp_data.line_level);
               end
               if (rsp_data.busy_res !== due.busy_res) begin
                  err_cnt++;
                  if (err_cnt <= MAX_SHOWN)
                     $display("%0t: busy_res expected %b got %b", $time,
                              due.busy_res, rsp_data.busy_res);
               end
               if (rsp_data.rejected !== due.rejected) begin
                  err_cnt++;
                  if (err_cnt <= MAX_SHOWN)
                     $display("%0t: rejected expected %b got %b", $time,
                              due.rejected, rsp_data.rejected);
               end
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("%0t: run timed out, %0d results still due", $time, slot_rsp_q.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic ledfs_pkg::req_type mk_word(input logic [2:0] op, input logic [6:0] idx);
      ledfs_pkg::req_type w;
      w.opcode      = op;
      w.pixel_index = idx;
      w.red         = 8'($urandom());
      w.green       = 8'($urandom());
      w.blue        = 8'($urandom());
      w.fill_value  = 8'($urandom());
      return w;
   endfunction

   task automatic push_word(input ledfs_pkg::req_type w);
      word_q.push_back(w);
      words_queued++;
   endtask

   task automatic push_rgb(input logic [2:0] op, input logic [6:0] idx,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      ledfs_pkg::req_type w;
      w       = mk_word(op, idx);
      w.red   = r;
      w.green = g;
      w.blue  = b;
      push_word(w);
   endtask

   task automatic push_fill(input logic [7:0] value);
      ledfs_pkg::req_type w;
      w            = mk_word(ledfs_pkg::OP_FILL, 7'($urandom()));
      w.fill_value = value;
      push_word(w);
   endtask

   task automatic push_ticks(input int unsigned cnt);
      repeat (cnt) push_word(mk_word(ledfs_pkg::OP_TICK, 7'($urandom())));
   endtask

   // Hold until every queued word is sent, every result is in and the block is free
   task automatic drain();
      do @(negedge clock);
      while (word_q.size() != 0 || start || busy || slot_rsp_q.size() != 0);
   endtask

   // Tick out any frame or gap still running
   task automatic settle_idle();
      int unsigned n;
      drain();
      while (snd_state != SEND_IDLE) begin
         if (snd_state == SEND_DATA)
            n = (frame_len - byte_ptr) * 40 + 32'(gap_len);
         else
            n = 32'(gap_left);
         push_ticks(n);
         drain();
      end
   endtask

   task automatic set_gap(input logic [15:0] slots);
      settle_idle();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= slots;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      logic [2:0]  op;
      logic [6:0]  cnt;
      logic [15:0] gap_now;
      int unsigned total, seqs, steps, pick;

      // Start the predictor from the reset state
      foreach (store_mem[i])
         store_mem[i] = 8'h00;
      snd_state = SEND_IDLE;
      byte_ptr  = 0;
      bit_ptr   = 3'd7;
      slot_cnt  = 0;
      gap_left  = '0;
      frame_len = 0;
      gap_len   = ledfs_pkg::RESET_SLOTS_DEFAULT;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      idle_en = 1'b1;

      // Directed: idle tick, bad indexes, unused opcodes, clamped counts
      push_ticks(1);
      push_rgb(ledfs_pkg::OP_SET_PIXEL, 7'd0, 8'h11, 8'h22, 8'h33);
      push_rgb(ledfs_pkg::OP_SET_PIXEL, 7'd65, 8'h11, 8'h22, 8'h33);
      push_rgb(ledfs_pkg::OP_SET_PIXEL, 7'd127, 8'h11, 8'h22, 8'h33);
      for (int unsigned k = 32'(ledfs_pkg::OP_TICK) + 1; k < 8; k++)
         push_word(mk_word(3'(k), 7'($urandom())));
      push_fill(8'h3c);
      push_rgb(ledfs_pkg::OP_SET_FIRST, 7'd0, 8'h00, 8'h00, 8'h00);
      push_rgb(ledfs_pkg::OP_SET_FIRST, 7'd127, 8'hff, 8'h00, 8'haa);
      push_rgb(ledfs_pkg::OP_SET_PIXEL, 7'd1, 8'hff, 8'h00, 8'ha5);
      push_rgb(ledfs_pkg::OP_SET_PIXEL, 7'd64, 8'h00, 8'hff, 8'h5a);

      // One-pixel frame, words refused during data and during the gap
      set_gap(16'd3);
      push_rgb(ledfs_pkg::OP_REFRESH, 7'd1, 8'h00, 8'h00, 8'h00);
      push_ticks(60);
      push_rgb(ledfs_pkg::OP_SET_PIXEL, 7'd3, 8'h12, 8'h34, 8'h56);
      push_ticks(62);
      push_rgb(ledfs_pkg::OP_REFRESH, 7'd1, 8'h00, 8'h00, 8'h00);
      push_ticks(2);

      // Zero gap: empty frame goes straight to idle, one-pixel frame ends with no gap
      set_gap(16'd0);
      push_rgb(ledfs_pkg::OP_REFRESH, 7'd0, 8'h00, 8'h00, 8'h00);
      push_ticks(1);
      push_fill(8'hff);
      push_rgb(ledfs_pkg::OP_REFRESH, 7'd1, 8'h00, 8'h00, 8'h00);
      push_ticks(122);
      push_fill(8'h00);

      // Empty frame followed by a 200-slot gap
      set_gap(16'd200);
      push_rgb(ledfs_pkg::OP_REFRESH, 7'd0, 8'h00, 8'h00, 8'h00);
      push_ticks(201);

      // Random: short frames with random content, noise words mixed in
      while (words_queued < RANDOM_STOP) begin
         gap_now = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
         set_gap(gap_now);
         idle_en = (words_queued < ITEM_TARGET * 9 / 10) && ($urandom_range(0, 3) != 0);
         seqs = $urandom_range(2, 4);
         repeat (seqs) begin
            steps = $urandom_range(1, 6);
            repeat (steps) begin
               pick = $urandom_range(0, 9);
               if (pick < 4) begin
                  cnt = ($urandom_range(0, 7) == 0) ? 7'($urandom())
                                                    : 7'($urandom_range(1, 64));
                  push_word(mk_word(ledfs_pkg::OP_SET_PIXEL, cnt));
               end else if (pick < 6) begin
                  cnt = ($urandom_range(0, 7) == 0) ? 7'($urandom())
                                                    : 7'($urandom_range(0, 4));
                  push_word(mk_word(ledfs_pkg::OP_SET_FIRST, cnt));
               end else if (pick == 6) begin
                  push_fill(8'($urandom()));
               end else if (pick == 7) begin
                  op = 3'($urandom_range(32'(ledfs_pkg::OP_TICK) + 1, 7));
                  push_word(mk_word(op, 7'($urandom())));
               end else begin
                  push_ticks($urandom_range(1, 3));
               end
            end
            if ($urandom_range(0, 2) == 0) begin
               pick = $urandom_range(0, 9);
               if (pick < 3)
                  cnt = 7'd0;
               else if (pick == 3)
                  cnt = 7'd2;
               else
                  cnt = 7'd1;
               push_word(mk_word(ledfs_pkg::OP_REFRESH, cnt));
               total = pixel_count(cnt) * 120 + 32'(gap_now) + $urandom_range(0, 3);
               repeat (total) begin
                  // Drop a stray word in now and then while the frame runs
                  if ($urandom_range(0, 24) == 0) begin
                     op = 3'($urandom_range(0, 5));
                     if (op >= ledfs_pkg::OP_REFRESH)
                        op = op + 3'd2;
                     push_word(mk_word(op, 7'($urandom())));
                  end
                  push_ticks(1);
               end
            end
         end
      end

      // Clamped full-chain refresh at the longest gap, refused words during data
      set_gap(16'hffff);
      idle_en = 1'b0;
      push_rgb(ledfs_pkg::OP_REFRESH, 7'd127, 8'h00, 8'h00, 8'h00);
      push_ticks(45);
      push_rgb(ledfs_pkg::OP_SET_PIXEL, 7'd2, 8'h01, 8'h02, 8'h03);
      push_fill(8'h80);
      push_ticks(5);
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      @(negedge clock);
      if (slot_rsp_q.size() != 0) begin
         err_cnt++;
         $display("%0t: results never arrived: expected 0 due got %0d",
                  $time, slot_rsp_q.size());
      end
      $display("Sent %0d words (%0d refused) and checked %0d results in %0d cycles;",
               words_taken, words_refused, rsp_checked, cycle_cnt);
      $display("%0d frames with zero, short, 200-slot and clamped runs, %0d errors.",
               frames_sent, err_cnt);
      if (err_cnt == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
